// ----- rtl/core/bfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Best-fit segment allocator package
// Shared codes and the control bundle passed from the sequencer to the cells.
// ----------------------------------------------------------------------------
package bfsa_pkg;

	localparam int OWNER_BITS = 16;
	localparam int PORT_BITS  = 16;
	localparam int SLACK_BITS = 8;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_NOOWNER = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic REG_MEMORY_UNITS = 1'b0;
	localparam logic REG_SPLIT_SLACK  = 1'b1;

	localparam logic [2:0] OP_HOLD    = 3'd0;
	localparam logic [2:0] OP_ROTATE  = 3'd1;
	localparam logic [2:0] OP_INIT    = 3'd2;
	localparam logic [2:0] OP_GRANT   = 3'd3;
	localparam logic [2:0] OP_SPLIT   = 3'd4;
	localparam logic [2:0] OP_RELEASE = 3'd5;
	localparam logic [2:0] OP_MERGE   = 3'd6;

	typedef struct packed {
		logic [2:0]            op;
		logic [OWNER_BITS-1:0] owner;
	} cell_ctl_t;

endpackage

// ----- rtl/core/best_fit_segment_allocator.sv -----
// ----------------------------------------------------------------------------
// Best-fit segment allocator
// Address-ordered segment table in a row of cells with a scanning sequencer.
// ----------------------------------------------------------------------------
// A request is offered on start with cmd, owner_id and request_size; the
// transfer takes place on a clock edge where start is high and busy is low.
// An allocate picks the smallest free segment that fits, lowest address on
// ties, and splits it when the leftover exceeds split_slack. A free releases
// the lowest-addressed segment of the owner and merges free neighbours.
// For each request the table rotates once through the cell row so that the
// sequencer sees every entry at the head cell; the apply state then grants,
// splits or releases an entry and, for a free, the merge states S_MERGEN and
// S_MERGEP merge the next and the previous free neighbour.
// The result appears on status, grant_address and grant_size with done high
// for one cycle, in the same cycle that busy falls; it cannot be held off.
// After reset the table holds one free segment of 1024 units and
// split_slack is 3. Writing memory_units through the configuration port
// rebuilds the table as one free segment.
// ----------------------------------------------------------------------------
module best_fit_segment_allocator #(
	parameter int MAX_SEGMENTS = 64,
	parameter int ADDR_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [15:0] owner_id,
	input  logic [15:0] request_size,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] grant_address,
	output logic [15:0] grant_size,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam int IDX_BITS = $clog2(MAX_SEGMENTS);
	localparam int CNT_BITS = $clog2(MAX_SEGMENTS + 1);
	localparam logic [32:0] AMAX = (33'd1 << ADDR_BITS) - 33'd1;
	localparam logic [32:0] MU_RESET = (33'd1024 > AMAX) ? AMAX : 33'd1024;
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(MAX_SEGMENTS);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_APPLY  = 3'd2;
	localparam logic [2:0] S_MERGEN = 3'd3;
	localparam logic [2:0] S_MERGEP = 3'd4;

	localparam int OB = bfsa_pkg::OWNER_BITS;

	logic [2:0]            state_q;
	logic [IDX_BITS-1:0]   k_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [7:0]            slack_q;
	logic                  cmd_q;
	logic [OB-1:0]         owner_q;
	logic [15:0]           req_q;
	logic                  found_q;
	logic [IDX_BITS-1:0]   bidx_q;
	logic [ADDR_BITS-1:0]  bstart_q, bsize_q;
	logic                  last_free_q, prevf_q, nextf_q;
	logic                  done_q;
	logic [1:0]            status_q;
	logic [15:0]           addr_q, gsize_q;

	logic [ADDR_BITS-1:0]  c_start [MAX_SEGMENTS];
	logic [ADDR_BITS-1:0]  c_size  [MAX_SEGMENTS];
	logic                  c_free  [MAX_SEGMENTS];
	logic [OB-1:0]         c_owner [MAX_SEGMENTS];

	bfsa_pkg::cell_ctl_t   ctl;
	logic [IDX_BITS-1:0]   pos;
	logic [ADDR_BITS-1:0]  a_start, a_size;

	logic        head_valid, cand_alloc, cand_free, whole, mu_write;
	logic [32:0] req_w, head_w, bsize_w, slack_w, mu_w;
	logic [ADDR_BITS-1:0] mu_sat;

	function automatic logic [15:0] PORT_W(input logic [ADDR_BITS-1:0] v);
		return 16'(v);
	endfunction

	assign req_w   = 33'(req_q);
	assign head_w  = 33'(c_size[0]);
	assign bsize_w = 33'(bsize_q);
	assign slack_w = 33'(slack_q);
	assign mu_w    = 33'(cfg_wdata);
	assign mu_sat  = ADDR_BITS'((mu_w > AMAX) ? AMAX : mu_w);
	assign mu_write = cfg_we && (cfg_index == bfsa_pkg::REG_MEMORY_UNITS);

	assign head_valid = CNT_BITS'(k_q) < count_q;
	assign cand_alloc = head_valid && c_free[0] && (req_q != '0) && (head_w >= req_w)
		&& (!found_q || (c_size[0] < bsize_q));
	assign cand_free  = head_valid && !c_free[0] && (c_owner[0] == owner_q) && !found_q;
	assign whole      = bsize_w <= (req_w + slack_w);

	always_comb begin
		ctl.op    = bfsa_pkg::OP_HOLD;
		ctl.owner = owner_q;
		pos       = bidx_q;
		a_start   = ADDR_BITS'(33'(bstart_q) + req_w);
		a_size    = ADDR_BITS'(req_w);
		if (mu_write) begin
			ctl.op = bfsa_pkg::OP_INIT;
			a_size = mu_sat;
		end else begin
			unique case (state_q)
				S_SCAN: ctl.op = bfsa_pkg::OP_ROTATE;
				S_APPLY: begin
					if (found_q) begin
						if (cmd_q == bfsa_pkg::CMD_FREE) begin
							ctl.op = bfsa_pkg::OP_RELEASE;
						end else if (whole) begin
							ctl.op = bfsa_pkg::OP_GRANT;
						end else if (count_q != CNT_FULL) begin
							ctl.op = bfsa_pkg::OP_SPLIT;
						end
					end
				end
				S_MERGEN: begin
					if (nextf_q) begin
						ctl.op = bfsa_pkg::OP_MERGE;
					end
				end
				S_MERGEP: begin
					pos = bidx_q - IDX_BITS'(1);
					if (prevf_q) begin
						ctl.op = bfsa_pkg::OP_MERGE;
					end
				end
				default: ctl.op = bfsa_pkg::OP_HOLD;
			endcase
		end
	end

	// In a split the remainder size reaches its cell through nxt_size.
	logic [ADDR_BITS-1:0] rem_size;
	assign rem_size = bsize_q - ADDR_BITS'(req_w);

	for (genvar j = 0; j < MAX_SEGMENTS; j++) begin : g_cell
		localparam int NX = (j == MAX_SEGMENTS - 1) ? 0 : j + 1;
		localparam int PV = (j == 0) ? 0 : j - 1;
		logic [ADDR_BITS-1:0] nsize;
		assign nsize = (ctl.op == bfsa_pkg::OP_SPLIT) ? rem_size : c_size[NX];
		bfsa_cell #(
			.ADDR_BITS (ADDR_BITS),
			.IDX_BITS  (IDX_BITS),
			.CELL_INDEX(j),
			.IS_LAST   (j == MAX_SEGMENTS - 1),
			.RESET_SIZE(ADDR_BITS'(MU_RESET))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.pos      (pos),
			.a_start  (a_start),
			.a_size   (a_size),
			.prv_start(c_start[PV]),
			.prv_size (c_size[PV]),
			.prv_free (c_free[PV]),
			.prv_owner(c_owner[PV]),
			.nxt_start(c_start[NX]),
			.nxt_size (nsize),
			.nxt_free (c_free[NX]),
			.nxt_owner(c_owner[NX]),
			.seg_start(c_start[j]),
			.seg_size (c_size[j]),
			.seg_free (c_free[j]),
			.seg_owner(c_owner[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			count_q     <= CNT_BITS'(1);
			slack_q     <= 8'd3;
			found_q     <= 1'b0;
			last_free_q <= 1'b0;
			prevf_q     <= 1'b0;
			nextf_q     <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == bfsa_pkg::REG_MEMORY_UNITS) begin
					count_q <= CNT_BITS'(1);
				end else begin
					slack_q <= cfg_wdata[7:0];
				end
			end
			unique case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						cmd_q       <= cmd;
						owner_q     <= owner_id;
						req_q       <= request_size;
						k_q         <= '0;
						found_q     <= 1'b0;
						last_free_q <= 1'b0;
						prevf_q     <= 1'b0;
						nextf_q     <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					done_q      <= 1'b0;
					last_free_q <= c_free[0];
					if ((cmd_q == bfsa_pkg::CMD_ALLOC) ? cand_alloc : cand_free) begin
						found_q  <= 1'b1;
						bidx_q   <= k_q;
						bstart_q <= c_start[0];
						bsize_q  <= c_size[0];
						prevf_q  <= last_free_q;
					end
					if (found_q && head_valid
						&& (CNT_BITS'(k_q) == CNT_BITS'(bidx_q) + CNT_BITS'(1))) begin
						nextf_q <= c_free[0];
					end
					k_q <= k_q + IDX_BITS'(1);
					if (CNT_BITS'(k_q) == CNT_FULL - CNT_BITS'(1)) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (!found_q) begin
						status_q <= (cmd_q == bfsa_pkg::CMD_FREE) ?
							bfsa_pkg::ST_NOOWNER : bfsa_pkg::ST_NOFIT;
						addr_q   <= '0;
						gsize_q  <= '0;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (cmd_q == bfsa_pkg::CMD_FREE) begin
						status_q <= bfsa_pkg::ST_OK;
						addr_q   <= '0;
						gsize_q  <= PORT_W(bsize_q);
						done_q   <= 1'b0;
						state_q  <= S_MERGEN;
					end else if (whole) begin
						status_q <= bfsa_pkg::ST_OK;
						addr_q   <= PORT_W(bstart_q);
						gsize_q  <= PORT_W(bsize_q);
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (count_q == CNT_FULL) begin
						status_q <= bfsa_pkg::ST_FULL;
						addr_q   <= '0;
						gsize_q  <= '0;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						status_q <= bfsa_pkg::ST_OK;
						addr_q   <= PORT_W(bstart_q);
						gsize_q  <= req_q;
						count_q  <= count_q + CNT_BITS'(1);
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_MERGEN: begin
					done_q <= 1'b0;
					if (nextf_q) begin
						count_q <= count_q - CNT_BITS'(1);
					end
					state_q <= S_MERGEP;
				end
				S_MERGEP: begin
					if (prevf_q) begin
						count_q <= count_q - CNT_BITS'(1);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = state_q != S_IDLE;
	assign done          = done_q;
	assign status        = status_q;
	assign grant_address = addr_q;
	assign grant_size    = gsize_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CNT_FULL))
		else $error("segment count out of range");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in progress");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not start");

	a_head_split: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == bfsa_pkg::OP_SPLIT) |-> (count_q < CNT_FULL))
		else $error("split into a full table");

endmodule

// ----- rtl/core/bfsa_cell.sv -----
// ----------------------------------------------------------------------------
// Segment cell
// Holds one table entry and moves it to or from its neighbours on command.
// ----------------------------------------------------------------------------
module bfsa_cell #(
	parameter int ADDR_BITS  = 16,
	parameter int IDX_BITS   = 6,
	parameter int CELL_INDEX = 0,
	parameter bit IS_LAST    = 1'b0,
	parameter logic [ADDR_BITS-1:0] RESET_SIZE = '0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bfsa_pkg::cell_ctl_t            ctl,
	input  logic [IDX_BITS-1:0]            pos,
	input  logic [ADDR_BITS-1:0]           a_start,
	input  logic [ADDR_BITS-1:0]           a_size,
	input  logic [ADDR_BITS-1:0]           prv_start,
	input  logic [ADDR_BITS-1:0]           prv_size,
	input  logic                           prv_free,
	input  logic [bfsa_pkg::OWNER_BITS-1:0] prv_owner,
	input  logic [ADDR_BITS-1:0]           nxt_start,
	input  logic [ADDR_BITS-1:0]           nxt_size,
	input  logic                           nxt_free,
	input  logic [bfsa_pkg::OWNER_BITS-1:0] nxt_owner,
	output logic [ADDR_BITS-1:0]           seg_start,
	output logic [ADDR_BITS-1:0]           seg_size,
	output logic                           seg_free,
	output logic [bfsa_pkg::OWNER_BITS-1:0] seg_owner
);

	localparam logic [IDX_BITS:0] ME = (IDX_BITS+1)'(CELL_INDEX);

	logic [ADDR_BITS-1:0]            start_q, size_q, start_d, size_d;
	logic                            free_q, free_d;
	logic [bfsa_pkg::OWNER_BITS-1:0] owner_q, owner_d;
	logic [IDX_BITS:0]               pos_x, pos_n;

	assign pos_x = {1'b0, pos};
	assign pos_n = pos_x + (IDX_BITS+1)'(1);

	always_comb begin
		start_d = start_q;
		size_d  = size_q;
		free_d  = free_q;
		owner_d = owner_q;
		unique case (ctl.op)
			bfsa_pkg::OP_ROTATE: begin
				start_d = nxt_start;
				size_d  = nxt_size;
				free_d  = nxt_free;
				owner_d = nxt_owner;
			end
			bfsa_pkg::OP_INIT: begin
				start_d = '0;
				size_d  = (CELL_INDEX == 0) ? a_size : '0;
				free_d  = (CELL_INDEX == 0);
				owner_d = '0;
			end
			bfsa_pkg::OP_GRANT: begin
				if (ME == pos_x) begin
					free_d  = 1'b0;
					owner_d = ctl.owner;
				end
			end
			bfsa_pkg::OP_SPLIT: begin
				if (ME == pos_x) begin
					size_d  = a_size;
					free_d  = 1'b0;
					owner_d = ctl.owner;
				end else if (ME == pos_n) begin
					start_d = a_start;
					size_d  = nxt_size;
					free_d  = 1'b1;
					owner_d = '0;
				end else if (ME > pos_n) begin
					start_d = prv_start;
					size_d  = prv_size;
					free_d  = prv_free;
					owner_d = prv_owner;
				end
			end
			bfsa_pkg::OP_RELEASE: begin
				if (ME == pos_x) begin
					free_d  = 1'b1;
					owner_d = '0;
				end
			end
			bfsa_pkg::OP_MERGE: begin
				if (ME == pos_x) begin
					size_d = size_q + nxt_size;
				end else if (ME > pos_x) begin
					start_d = IS_LAST ? '0 : nxt_start;
					size_d  = IS_LAST ? '0 : nxt_size;
					free_d  = IS_LAST ? 1'b0 : nxt_free;
					owner_d = IS_LAST ? '0 : nxt_owner;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			size_q  <= (CELL_INDEX == 0) ? RESET_SIZE : '0;
			free_q  <= (CELL_INDEX == 0);
			owner_q <= '0;
		end else begin
			start_q <= start_d;
			size_q  <= size_d;
			free_q  <= free_d;
			owner_q <= owner_d;
		end
	end

	assign seg_start = start_q;
	assign seg_size  = size_q;
	assign seg_free  = free_q;
	assign seg_owner = owner_q;

endmodule

// ----- test/tb_best_fit_segment_allocator.sv -----
// ----------------------------------------------------------------------------
// Best-fit segment allocator testbench
// Drives allocate and free requests through the command handshake and checks
// every result against a table-based prediction, across several settings.
// ----------------------------------------------------------------------------
module tb_best_fit_segment_allocator;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEGS = 64;

	typedef struct {
		logic        op;
		logic [15:0] owner;
		logic [15:0] units;
	} request_t;

	typedef struct {
		logic [1:0]  st;
		logic [15:0] addr;
		logic [15:0] units;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        cmd = bfsa_pkg::CMD_ALLOC;
	logic [15:0] owner_id = '0;
	logic [15:0] request_size = '0;
	logic        done;
	logic [1:0]  status;
	logic [15:0] grant_address;
	logic [15:0] grant_size;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = bfsa_pkg::REG_MEMORY_UNITS;
	logic [15:0] cfg_wdata = '0;

	request_t pending_requests[$];
	grant_t   expected_grants[$];
	int       error_count = 0;
	bit       gaps_on = 1'b1;

	logic [15:0] tab_start[SEGS];
	logic [15:0] tab_size[SEGS];
	bit          tab_free[SEGS];
	logic [15:0] tab_owner[SEGS];
	int          tab_count;
	logic [15:0] mem_units;
	logic [7:0]  slack;

	best_fit_segment_allocator DUT (.*);

	always #5 clk = ~clk;

	function automatic void rebuild_table();
		for (int i = 0; i < SEGS; i++) begin
			tab_start[i] = '0;
			tab_size[i] = '0;
			tab_free[i] = 1'b0;
			tab_owner[i] = '0;
		end
		tab_size[0] = mem_units;
		tab_free[0] = 1'b1;
		tab_count = 1;
	endfunction

	function automatic grant_t allocate_or_release(request_t rq);
		grant_t g;
		int best;
		int w;
		bit found;
		g = '{bfsa_pkg::ST_OK, 16'd0, 16'd0};
		best = 0;
		found = 1'b0;
		if (rq.op == bfsa_pkg::CMD_ALLOC) begin
			if (rq.units != 0) begin
				for (int i = 0; i < tab_count; i++) begin
					if (tab_free[i] && tab_size[i] >= rq.units &&
					    (!found || tab_size[i] < tab_size[best])) begin
						best = i;
						found = 1'b1;
					end
				end
			end
			if (!found) begin
				g.st = bfsa_pkg::ST_NOFIT;
			end else if (32'(tab_size[best]) <= 32'(rq.units) + 32'(slack)) begin
				tab_free[best] = 1'b0;
				tab_owner[best] = rq.owner;
				g.addr = tab_start[best];
				g.units = tab_size[best];
			end else if (tab_count >= SEGS) begin
				g.st = bfsa_pkg::ST_FULL;
			end else begin
				for (int i = tab_count; i > best + 1; i--) begin
					tab_start[i] = tab_start[i-1];
					tab_size[i] = tab_size[i-1];
					tab_free[i] = tab_free[i-1];
					tab_owner[i] = tab_owner[i-1];
				end
				tab_start[best+1] = tab_start[best] + rq.units;
				tab_size[best+1] = tab_size[best] - rq.units;
				tab_free[best+1] = 1'b1;
				tab_owner[best+1] = '0;
				tab_size[best] = rq.units;
				tab_free[best] = 1'b0;
				tab_owner[best] = rq.owner;
				tab_count++;
				g.addr = tab_start[best];
				g.units = rq.units;
			end
		end else begin
			for (int i = 0; i < tab_count; i++) begin
				if (!found && !tab_free[i] && tab_owner[i] == rq.owner) begin
					best = i;
					found = 1'b1;
				end
			end
			if (!found) begin
				g.st = bfsa_pkg::ST_NOOWNER;
			end else begin
				tab_free[best] = 1'b1;
				tab_owner[best] = '0;
				g.units = tab_size[best];
				w = 0;
				for (int r = 1; r < tab_count; r++) begin
					if (tab_free[w] && tab_free[r]) begin
						tab_size[w] = tab_size[w] + tab_size[r];
					end else begin
						w++;
						tab_start[w] = tab_start[r];
						tab_size[w] = tab_size[r];
						tab_free[w] = tab_free[r];
						tab_owner[w] = tab_owner[r];
					end
				end
				tab_count = w + 1;
				for (int r = tab_count; r < SEGS; r++) begin
					tab_start[r] = '0;
					tab_size[r] = '0;
					tab_free[r] = 1'b0;
					tab_owner[r] = '0;
				end
			end
		end
		return g;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	// Driver: offers the next pending request, holding it until the transfer.
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				pending_requests.pop_front();
			end
			if (!(start && busy)) begin
				if (pending_requests.size() > 0 &&
				    (!gaps_on || $urandom_range(99) >= 36)) begin
					start <= 1'b1;
					cmd <= pending_requests[0].op;
					owner_id <= pending_requests[0].owner;
					request_size <= pending_requests[0].units;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: predicts on each accepted request and checks each result.
	always @(posedge clk) begin
		grant_t want;
		request_t rq;
		if (arst_n) begin
			if (done) begin
				if (expected_grants.size() == 0) begin
					report_mismatch("unexpected result", 16'd1, 16'd0);
				end else begin
					want = expected_grants.pop_front();
					if (status !== want.st)
						report_mismatch("status", 16'(status), 16'(want.st));
					if (grant_address !== want.addr)
						report_mismatch("grant_address", grant_address, want.addr);
					if (grant_size !== want.units)
						report_mismatch("grant_size", grant_size, want.units);
				end
			end
			if (start && !busy) begin
				rq = '{cmd, owner_id, request_size};
				expected_grants.push_back(allocate_or_release(rq));
			end
		end
	end

	task automatic push_request(logic op, logic [15:0] owner, logic [15:0] units);
		pending_requests.push_back('{op, owner, units});
	endtask

	task automatic drain();
		while (pending_requests.size() > 0 || expected_grants.size() > 0 || start)
			@(posedge clk);
		repeat (SEGS + 10) @(posedge clk);
	endtask

	task automatic write_register(logic [0:0] idx, logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == bfsa_pkg::REG_MEMORY_UNITS) begin
			mem_units = value;
			rebuild_table();
		end else begin
			slack = value[7:0];
		end
	endtask

	task automatic random_phase(int count, int size_max, int owners);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 55)
				push_request(bfsa_pkg::CMD_ALLOC, 16'($urandom_range(owners)),
				             16'($urandom_range(size_max, 1)));
			else if ($urandom_range(99) < 5)
				push_request(bfsa_pkg::CMD_ALLOC, 16'($urandom), 16'($urandom));
			else
				push_request(bfsa_pkg::CMD_FREE, 16'($urandom_range(owners + 1)),
				             16'($urandom));
		end
	endtask

	initial begin
		mem_units = 16'd1024;
		slack = 8'd3;
		rebuild_table();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_request(bfsa_pkg::CMD_ALLOC, 16'd0, 16'd0);
		push_request(bfsa_pkg::CMD_ALLOC, 16'hFFFF, 16'd100);
		push_request(bfsa_pkg::CMD_ALLOC, 16'd7, 16'd1);
		push_request(bfsa_pkg::CMD_ALLOC, 16'd7, 16'd1);
		push_request(bfsa_pkg::CMD_ALLOC, 16'd9, 16'd919);
		push_request(bfsa_pkg::CMD_ALLOC, 16'd5, 16'hFFFF);
		push_request(bfsa_pkg::CMD_FREE, 16'd7, 16'hFFFF);
		push_request(bfsa_pkg::CMD_FREE, 16'd7, 16'd0);
		push_request(bfsa_pkg::CMD_FREE, 16'd7, 16'd0);
		push_request(bfsa_pkg::CMD_FREE, 16'h1234, 16'd0);
		push_request(bfsa_pkg::CMD_FREE, 16'hFFFF, 16'd0);
		push_request(bfsa_pkg::CMD_FREE, 16'd9, 16'd0);
		drain();

		write_register(bfsa_pkg::REG_SPLIT_SLACK, 16'd0);
		for (int i = 0; i < 70; i++)
			push_request(bfsa_pkg::CMD_ALLOC, 16'(i + 1), 16'd1);
		drain();

		write_register(bfsa_pkg::REG_MEMORY_UNITS, 16'd0);
		push_request(bfsa_pkg::CMD_ALLOC, 16'd1, 16'd1);
		push_request(bfsa_pkg::CMD_ALLOC, 16'd1, 16'd0);
		push_request(bfsa_pkg::CMD_FREE, 16'd1, 16'd0);
		drain();

		write_register(bfsa_pkg::REG_MEMORY_UNITS, 16'hFFFF);
		write_register(bfsa_pkg::REG_SPLIT_SLACK, 16'd255);
		random_phase(300, 4000, 20);
		drain();

		write_register(bfsa_pkg::REG_MEMORY_UNITS, 16'd1);
		write_register(bfsa_pkg::REG_SPLIT_SLACK, 16'd0);
		random_phase(60, 2, 3);
		drain();

		gaps_on = 1'b0;
		write_register(bfsa_pkg::REG_MEMORY_UNITS, 16'd500);
		write_register(bfsa_pkg::REG_SPLIT_SLACK, 16'd2);
		random_phase(300, 40, 12);
		drain();

		gaps_on = 1'b1;
		write_register(bfsa_pkg::REG_MEMORY_UNITS, 16'd2000);
		write_register(bfsa_pkg::REG_SPLIT_SLACK, 16'd3);
		random_phase(500, 60, 70);
		drain();

		if (error_count == 0) begin
			$display("** best_fit_segment_allocator: PASSED **");
		end else begin
			$display("** best_fit_segment_allocator: FAILED **");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("** best_fit_segment_allocator: FAILED **");
		$finish;
	end
endmodule
